/* hdl/bbfg_pkg.sv */
`default_nettype none

package bbfg_pkg;

  // Largest bitmap side the column store is sized for
  localparam int MAX_SIDE = 1024;

  // Widths derived from the largest side
  localparam int POS_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = POS_W + 1;
  localparam int RUN_W  = SIDE_W;
  localparam int CHAR_W = POS_W - 2;
  localparam int SHIFT_W = $clog2(SIDE_W);

  // Character codes
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_F = 8'h46;

  // One column entry: last pixel seen and current run length
  typedef struct packed {
    logic             prev;
    logic [RUN_W-1:0] run;
  } col_entry_t;

  localparam int COL_W = $bits(col_entry_t);

  // Decode a hex character into four pixels; anything else reads as zero
  function automatic logic [3:0] nibble_of(input logic [7:0] ch);
    logic [7:0] d;
    d = 8'h00;
    if (ch >= CH_0 && ch <= CH_9) begin
      d = ch - CH_0;
    end else if (ch >= CH_A && ch <= CH_F) begin
      d = ch - CH_A + 8'd10;
    end
    return d[3:0];
  endfunction

  // Clamp a side length into range and round down to a multiple of four
  function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] s;
    s = v;
    if (s < SIDE_W'(4)) begin
      s = SIDE_W'(4);
    end
    if (s > SIDE_W'(MAX_SIDE)) begin
      s = SIDE_W'(MAX_SIDE);
    end
    return {s[SIDE_W-1:2], 2'b00};
  endfunction

endpackage

`default_nettype wire

/* hdl/bbfg_ram.sv */
`default_nettype none

module bbfg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/bbfg_gcd.sv */
`default_nettype none

module bbfg_gcd
  import bbfg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [RUN_W-1:0] a_in,
  input  wire logic [RUN_W-1:0] b_in,
  output logic                  done,
  output logic [RUN_W-1:0]      result
);

  logic               busy;
  logic [RUN_W-1:0]   a;
  logic [RUN_W-1:0]   b;
  logic [SHIFT_W-1:0] k;
  logic               finish;
  logic               a_gt_b;
  logic [RUN_W-1:0]   diff;
  logic [RUN_W-1:0]   base;

  // Binary gcd: one compare and subtract per cycle
  always_comb begin
    finish = (a == '0) || (b == '0) || (a == b);
    a_gt_b = a > b;
    diff   = a_gt_b ? (a - b) : (b - a);
    base   = (a == '0) ? b : a;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && finish) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Operands: strip common twos, halve even ones, subtract odd pairs
  always_ff @(posedge clk) begin
    if (start) begin
      a <= a_in;
      b <= b_in;
      k <= '0;
    end else if (busy) begin
      if (finish) begin
        result <= base << k;
      end else if (!a[0] && !b[0]) begin
        a <= a >> 1;
        b <= b >> 1;
        k <= k + SHIFT_W'(1);
      end else if (!a[0]) begin
        a <= a >> 1;
      end else if (!b[0]) begin
        b <= b >> 1;
      end else if (a_gt_b) begin
        a <= diff >> 1;
      end else begin
        b <= diff >> 1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/bitmap_block_factor_gcd_unit.sv */
`default_nettype none

// Block factor of a square binary bitmap. Write the side length (4..1024, a
// multiple of four; other values are clamped and rounded down) while the block
// is idle; a write also restarts the bitmap. Then feed the bitmap row by row,
// one hex character (four pixels, MSB leftmost) per start pulse, taken when
// busy is low. After the last character of the last row, block_factor appears
// for exactly one cycle with done high; it cannot be held off, so capture it
// then. Each character is handled one pixel at a time: for every pixel the
// column-store read, the update and the fold check, plus for each closed run
// a hand-off to the shared binary gcd unit and its steps on the 11-bit run
// length. A character with no run ending needs no gcd work; one that closes
// the most runs (thirteen, on the last row) needs the most. The column store
// is one RAM of MAX_SIDE entries, filled by the first row of every bitmap.
module bitmap_block_factor_gcd_unit
  import bbfg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [SIDE_W-1:0] side_length,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [7:0]        hex_char,
  output logic                   done,
  output logic [SIDE_W-1:0]      block_factor
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_PIX  = 3'd2;
  localparam logic [2:0] S_FOLD = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;

  logic [2:0]        state;
  logic [1:0]        k_idx;
  logic [3:0]        nib;
  logic [POS_W-1:0]  row_index;
  logic [CHAR_W-1:0] char_in_row;
  logic              row_prev;
  logic [RUN_W-1:0]  row_run;
  logic [RUN_W-1:0]  acc;
  logic [SIDE_W-1:0] side;
  logic [3:0]        fold_pend;
  logic [RUN_W-1:0]  fold_val [4];

  logic [POS_W-1:0]  col;
  logic [POS_W-1:0]  side_m1;
  logic [CHAR_W-1:0] char_last;
  logic              pix;
  logic              last_pix;
  logic              last_row;
  logic              last_char;
  logic [RUN_W-1:0]  row_run_next;
  logic [RUN_W-1:0]  col_run_next;
  logic              row_chg;
  logic              col_chg;
  logic [1:0]        sel;
  col_entry_t        rd_entry;
  col_entry_t        wr_entry;
  logic              gcd_start;
  logic              gcd_done;
  logic [RUN_W-1:0]  gcd_result;
  logic [COL_W-1:0]  ram_rdata;

  assign busy = (state != S_IDLE);

  // Position decode for the current pixel
  always_comb begin
    col       = {char_in_row, k_idx};
    side_m1   = POS_W'(side - SIDE_W'(1));
    char_last = CHAR_W'((side >> 2) - SIDE_W'(1));
    pix       = nib[~k_idx];
    last_pix  = (col == side_m1);
    last_row  = (row_index == side_m1);
    last_char = (char_in_row == char_last);
  end

  // Run updates for row and column
  always_comb begin
    rd_entry = col_entry_t'(ram_rdata);
    row_chg  = (col != '0) && (pix != row_prev);
    col_chg  = (row_index != '0) && (pix != rd_entry.prev);
    if (col == '0 || row_chg) begin
      row_run_next = RUN_W'(1);
    end else begin
      row_run_next = row_run + RUN_W'(1);
    end
    if (row_index == '0 || col_chg) begin
      col_run_next = RUN_W'(1);
    end else begin
      col_run_next = rd_entry.run + RUN_W'(1);
    end
    wr_entry.prev = pix;
    wr_entry.run  = col_run_next;
  end

  // Pick the lowest pending run to fold
  always_comb begin
    sel = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (fold_pend[i]) begin
        sel = 2'(i);
      end
    end
  end

  assign gcd_start = (state == S_FOLD) && (fold_pend != '0);

  bbfg_ram #(
    .WIDTH(COL_W),
    .DEPTH(MAX_SIDE)
  ) u_col_ram (
    .clk  (clk),
    .we   (state == S_PIX),
    .waddr(col),
    .wdata(wr_entry),
    .raddr(col),
    .rdata(ram_rdata)
  );

  bbfg_gcd u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .a_in  (acc),
    .b_in  (fold_val[sel]),
    .done  (gcd_done),
    .result(gcd_result)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      side        <= eff_side(SIDE_W'(4));
      row_index   <= '0;
      char_in_row <= '0;
      row_prev    <= 1'b0;
      row_run     <= '0;
      acc         <= '0;
      fold_pend   <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_write) begin
            side        <= eff_side(side_length);
            row_index   <= '0;
            char_in_row <= '0;
            row_prev    <= 1'b0;
            row_run     <= '0;
            acc         <= '0;
          end else if (start) begin
            nib   <= nibble_of(hex_char);
            k_idx <= 2'd0;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_PIX;
        end
        S_PIX: begin
          // Queue the runs this pixel closes
          row_run     <= row_run_next;
          row_prev    <= pix;
          fold_val[0] <= row_run;
          fold_val[1] <= row_run_next;
          fold_val[2] <= rd_entry.run;
          fold_val[3] <= col_run_next;
          fold_pend   <= {last_row, col_chg, last_pix, row_chg};
          state       <= S_FOLD;
        end
        S_FOLD: begin
          if (fold_pend != '0) begin
            fold_pend[sel] <= 1'b0;
            state          <= S_WAIT;
          end else if (k_idx != 2'd3) begin
            k_idx <= k_idx + 2'd1;
            state <= S_RD;
          end else begin
            // Advance to the next character, closing out the bitmap
            state <= S_IDLE;
            if (!last_char) begin
              char_in_row <= char_in_row + CHAR_W'(1);
            end else begin
              char_in_row <= '0;
              if (last_row) begin
                block_factor <= acc;
                done         <= 1'b1;
                row_index    <= '0;
                row_prev     <= 1'b0;
                row_run      <= '0;
                acc          <= '0;
              end else begin
                row_index <= row_index + POS_W'(1);
              end
            end
          end
        end
        S_WAIT: begin
          if (gcd_done) begin
            acc   <= gcd_result;
            state <= S_FOLD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/sv/bitmap_block_factor_gcd_unit_tb.sv */
`default_nettype none

module bitmap_block_factor_gcd_unit_tb;
  import bbfg_pkg::*;

  localparam int ITEM_TARGET   = 1750;
  localparam int IDLE_CUTOFF   = 1450;
  localparam int MIN_BITMAPS   = 12;
  localparam int MAX_BITMAP    = 36;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT   = 5_000_000;

  // Tracks row and column runs and the running divisor of the current bitmap
  class factor_scoreboard;
    bit [SIDE_W-1:0] side_reg;
    int unsigned     row_pos;
    int unsigned     char_pos;
    bit              row_prev;
    bit [RUN_W-1:0]  row_run;
    bit [SIDE_W-1:0] divisor;
    bit              col_prev [MAX_SIDE];
    bit [RUN_W-1:0]  col_run [MAX_SIDE];
    bit [SIDE_W-1:0] expected_factors [$];
    int              errors;
    int              bitmaps;

    function new();
      side_reg = SIDE_W'(4);
      restart_bitmap();
      foreach (col_prev[i]) begin
        col_prev[i] = 1'b0;
        col_run[i]  = '0;
      end
      errors  = 0;
      bitmaps = 0;
    endfunction

    function void restart_bitmap();
      row_pos  = 0;
      char_pos = 0;
      row_prev = 1'b0;
      row_run  = '0;
      divisor  = '0;
    endfunction

    function void write_side(bit [SIDE_W-1:0] v);
      side_reg = v;
      restart_bitmap();
    endfunction

    // Clamp to the supported range, then round down to whole characters
    function int unsigned active_side();
      int unsigned s;
      s = side_reg;
      if (s < 4) s = 4;
      if (s > MAX_SIDE) s = MAX_SIDE;
      return s - (s % 4);
    endfunction

    function bit [3:0] pixels_of(bit [7:0] ch);
      if (ch >= CH_0 && ch <= CH_9) return 4'(ch - CH_0);
      if (ch >= CH_A && ch <= CH_F) return 4'(ch - CH_A + 8'd10);
      return 4'h0;
    endfunction

    // Fold a closed run into the divisor by Euclid's remainder steps
    function void fold_run(bit [RUN_W-1:0] len);
      int unsigned a, b, t;
      a = divisor;
      b = len;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      divisor = SIDE_W'(a);
    endfunction

    // Advance the runs by one accepted item
    function void note_char(bit [7:0] ch);
      int unsigned side, c;
      bit [3:0]    nib;
      bit          p;
      side = active_side();
      nib  = pixels_of(ch);
      if (row_pos >= side) row_pos = 0;
      if (char_pos >= side / 4) char_pos = 0;
      for (int k = 0; k < 4; k++) begin
        p = nib[3-k];
        c = char_pos * 4 + k;
        // row run
        if (c == 0) begin
          row_run = 1;
        end else if (p == row_prev) begin
          row_run++;
        end else begin
          fold_run(row_run);
          row_run = 1;
        end
        row_prev = p;
        if (c == side - 1) fold_run(row_run);
        // column run
        if (row_pos == 0) begin
          col_run[c] = 1;
        end else if (p == col_prev[c]) begin
          col_run[c]++;
        end else begin
          fold_run(col_run[c]);
          col_run[c] = 1;
        end
        col_prev[c] = p;
        if (row_pos == side - 1) fold_run(col_run[c]);
      end
      char_pos++;
      if (char_pos == side / 4) begin
        char_pos = 0;
        row_pos++;
        if (row_pos == side) begin
          expected_factors.push_back(divisor);
          bitmaps++;
          restart_bitmap();
        end
      end
    endfunction

    // Compare one emitted factor against the oldest finished bitmap
    function void check_factor(bit [SIDE_W-1:0] got);
      bit [SIDE_W-1:0] want;
      if (expected_factors.size() == 0) begin
        $display("%0t: block_factor expected none, got %0d", $time, got);
        errors++;
      end else begin
        want = expected_factors.pop_front();
        if (want !== got) begin
          $display("%0t: block_factor expected %0d, got %0d", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [SIDE_W-1:0] side_length;
  logic              start;
  logic              busy;
  logic [7:0]        hex_char;
  logic              done;
  logic [SIDE_W-1:0] block_factor;

  factor_scoreboard sb;
  int               items;
  int               cycles;
  bit               idle_on;

  bit [7:0] directed_chars [24] = '{
    "0", "0", "0", "0",
    "F", "F", "F", "F",
    "C", "C", "3", "3",
    "A", "5", "A", "5",
    8'hFF, "a", 8'h00, "G",
    "9", "6", "6", "9"
  };

  bitmap_block_factor_gcd_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .side_length  (side_length),
    .start        (start),
    .busy         (busy),
    .hex_char     (hex_char),
    .done         (done),
    .block_factor (block_factor)
  );

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL bitmap_block_factor_gcd_unit");
      $finish;
    end
  end

  // Capture each factor in its single strobe cycle
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      sb.check_factor(block_factor);
    end
  end

  // Pick a character for four pixels; blank pixels sometimes as a non-hex byte
  function automatic bit [7:0] char_for(bit [3:0] nib);
    bit [7:0] ch;
    if (nib == 4'h0 && $urandom_range(0, 3) == 0) begin
      do begin
        ch = 8'($urandom);
      end while ((ch >= CH_0 && ch <= CH_9) || (ch >= CH_A && ch <= CH_F));
      return ch;
    end
    if (nib < 4'd10) return CH_0 + 8'(nib);
    return CH_A + 8'(nib - 4'd10);
  endfunction

  // Drop start for a burst of cycles
  task automatic hold_off(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Present one item and hold it until the block takes it
  task automatic send_char(input bit [7:0] ch);
    if (idle_on && items < IDLE_CUTOFF && $urandom_range(0, 7) == 0) begin
      hold_off($urandom_range(1, 14));
    end
    @(negedge clk);
    start    <= 1'b1;
    hex_char <= ch;
    do @(posedge clk); while (busy);
    sb.note_char(ch);
    items++;
  endtask

  // Stop sending and wait for every finished bitmap's factor and an idle block
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_factors.size() != 0 || busy) @(negedge clk);
  endtask

  // Write the side register once the block has gone quiet
  task automatic set_side(input int v);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write   <= 1'b1;
    side_length <= SIDE_W'(v);
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.write_side(SIDE_W'(v));
  endtask

  // Send an upscaled random image, with a few flipped pixels at times, or random bytes when noise is set
  task automatic send_bitmap(input int side, input bit noise);
    bit img [0:MAX_BITMAP-1][0:MAX_BITMAP-1];
    int divs [$];
    int f;
    bit flat;
    bit flat_val;
    if (noise) begin
      repeat (side * side / 4) send_char(8'($urandom_range(0, 255)));
      return;
    end
    for (int d = 1; d <= side; d++) begin
      if (side % d == 0) divs.push_back(d);
    end
    f        = divs[$urandom_range(0, divs.size() - 1)];
    flat     = ($urandom_range(0, 7) == 0);
    flat_val = 1'($urandom_range(0, 1));
    for (int r = 0; r < side; r++) begin
      for (int c = 0; c < side; c++) begin
        if (r % f == 0 && c % f == 0) begin
          img[r][c] = flat ? flat_val : 1'($urandom_range(0, 1));
        end else begin
          img[r][c] = img[r - r % f][c - c % f];
        end
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        f = $urandom_range(0, side - 1);
        img[f][$urandom_range(0, side - 1)] ^= 1'b1;
      end
    end
    for (int r = 0; r < side; r++) begin
      for (int q = 0; q < side / 4; q++) begin
        send_char(char_for({img[r][4*q], img[r][4*q+1], img[r][4*q+2], img[r][4*q+3]}));
      end
    end
  endtask

  // Send part of a bitmap; the next register write discards it
  task automatic send_partial(input int n);
    repeat (n) send_char(char_for(4'($urandom)));
  endtask

  initial begin : stimulus
    int v;
    int side;
    clk         = 1'b0;
    rst         = 1'b1;
    cfg_write   = 1'b0;
    side_length = '0;
    start       = 1'b0;
    hex_char    = '0;
    items       = 0;
    cycles      = 0;
    idle_on     = 1'b1;
    sb          = new();
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Side from reset: flat, striped, checkered and non-hex bitmaps
    foreach (directed_chars[i]) send_char(directed_chars[i]);

    // Side below range clamps up to four
    set_side(0);
    repeat (2) send_bitmap(4, 1'b0);

    // Side above range clamps to the largest; fill row 0 and start row 1
    set_side(2047);
    send_partial(MAX_SIDE / 4 + 4);

    // Random phases, mostly small sides
    while (items < ITEM_TARGET || sb.bitmaps < MIN_BITMAPS) begin
      if ($urandom_range(0, 9) < 7) begin
        v = $urandom_range(0, 12);
      end else begin
        v = $urandom_range(13, MAX_BITMAP);
      end
      set_side(v);
      side    = sb.active_side();
      idle_on = ($urandom_range(0, 2) != 0);
      repeat ($urandom_range(1, 4)) begin
        if (items < ITEM_TARGET || sb.bitmaps < MIN_BITMAPS) begin
          send_bitmap(side, $urandom_range(0, 7) == 0);
        end
      end
      if (items < ITEM_TARGET && $urandom_range(0, 5) == 0) begin
        send_partial($urandom_range(1, side * side / 4 - 1));
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.expected_factors.size() == 0) begin
      $display("PASS bitmap_block_factor_gcd_unit");
    end else begin
      $display("FAIL bitmap_block_factor_gcd_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire
